// ----- rtl/core/jtag_sequence_shifter_core_defines.svh -----
// assertion macros for the checker file jss_checker.sv
`ifndef JTAG_SEQUENCE_SHIFTER_CORE_DEFINES_SVH
`define JTAG_SEQUENCE_SHIFTER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define JSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jss check failed");

// next-cycle implication, sampled on clk, off while in reset
`define JSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jss check failed");

`endif

// ----- rtl/core/jss_pkg.sv -----
`default_nettype none

package jss_pkg;

    typedef enum logic [1:0] {
        PH_COUNT,
        PH_INFO,
        PH_DATA,
        PH_SHIFT
    } phase_t;

    localparam logic [6:0] FULL_LEN  = 7'd64;
    localparam logic [6:0] BYTE_LEN  = 7'd8;
    localparam logic [3:0] BYTE_BITS = 4'd8;
    localparam logic [2:0] CAP_LAST  = 3'd7;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  sequences_left;
        logic [6:0]  bits_left;
        logic        tms_level;
        logic        capture_on;
        logic [7:0]  data_shift;
        logic [3:0]  bits_in_data;
        logic [7:0]  capture_acc;
        logic [2:0]  capture_pos;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:          PH_COUNT,
        sequences_left: 8'd0,
        bits_left:      7'd0,
        tms_level:      1'b0,
        capture_on:     1'b0,
        data_shift:     8'd0,
        bits_in_data:   4'd0,
        capture_acc:    8'd0,
        capture_pos:    3'd0
    };

    typedef struct packed {
        logic        tck_pulse;
        logic        tms;
        logic        tdi;
        logic        response_valid;
        logic [7:0]  response_byte;
        logic        byte_refused;
        logic        done_res;
        logic        need_byte;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/jtag_sequence_shifter_core.sv -----
// jtag sequence shifter: runs the body of a jtag sequence command
// input channel (in_valid/in_ready): one beat is either a request byte (operation 0:
//   sequence count, info byte, tdi data bytes) or a bit tick (operation 1) carrying
//   the tdo level sampled at that tick
// output channel (out_valid/out_ready): exactly one result beat per input beat, in
//   order, giving the tck pulse with its tms/tdi levels, a packed tdo response byte
//   when one completes, the refused and done flags, and whether a request byte is
//   expected next
// the accepted input beat is registered, then one pass of the step logic updates the
//   engine state and loads the result register, which drives the output
// throughput: one beat per cycle while the receiver does not stall, set by the single state update per beat
// when the receiver stalls, the result register holds, the input register fills
//   behind it and in_ready drops; no beat is lost or repeated
// reset clears the engine to wait for a sequence count and empties both registers
`default_nettype none

module jtag_sequence_shifter_core
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_ready,
    input  wire        operation,
    input  wire [7:0]  request_byte,
    input  wire        tdo_sample,
    output logic       out_valid,
    input  wire        out_ready,
    output logic       tck_pulse,
    output logic       tms,
    output logic       tdi,
    output logic       response_valid,
    output logic [7:0] response_byte,
    output logic       byte_refused,
    output logic       done_res,
    output logic       need_byte
);

    logic              in_valid_reg;
    logic              operation_reg;
    logic [7:0]        request_byte_reg;
    logic              tdo_sample_reg;
    logic              out_valid_reg;
    logic              advance;
    jss_pkg::state_t   state_reg;
    jss_pkg::state_t   state_next;
    jss_pkg::result_t  result_reg;
    jss_pkg::result_t  result_next;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    jss_step u_step
    (
        .state        (state_reg),
        .operation    (operation_reg),
        .request_byte (request_byte_reg),
        .tdo_sample   (tdo_sample_reg),
        .state_next   (state_next),
        .result       (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= jss_pkg::STATE_RESET;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            operation_reg    <= operation;
            request_byte_reg <= request_byte;
            tdo_sample_reg   <= tdo_sample;
        end
        if (advance)
            result_reg <= result_next;
    end

    assign out_valid      = out_valid_reg;
    assign tck_pulse      = result_reg.tck_pulse;
    assign tms            = result_reg.tms;
    assign tdi            = result_reg.tdi;
    assign response_valid = result_reg.response_valid;
    assign response_byte  = result_reg.response_byte;
    assign byte_refused   = result_reg.byte_refused;
    assign done_res       = result_reg.done_res;
    assign need_byte      = result_reg.need_byte;

endmodule

`default_nettype wire

// ----- rtl/core/jss_step.sv -----
`default_nettype none

module jss_step
(
    input  wire jss_pkg::state_t  state,
    input  wire                   operation,
    input  wire [7:0]             request_byte,
    input  wire                   tdo_sample,
    output jss_pkg::state_t       state_next,
    output jss_pkg::result_t      result
);

    always_comb
    begin
        logic [6:0] len;
        logic [7:0] acc;
        state_next = state;
        result     = '0;
        len        = {1'b0, request_byte[5:0]};
        acc        = state.capture_acc;

        if (!operation)
        begin
            case (state.phase)
                jss_pkg::PH_COUNT:
                begin
                    state_next.sequences_left = request_byte;
                    if (request_byte == 8'd0)
                        result.done_res = 1'b1;
                    else
                        state_next.phase = jss_pkg::PH_INFO;
                end
                jss_pkg::PH_INFO:
                begin
                    state_next.bits_left   = (len == 7'd0) ? jss_pkg::FULL_LEN : len;
                    state_next.tms_level   = request_byte[6];
                    state_next.capture_on  = request_byte[7];
                    state_next.capture_acc = 8'd0;
                    state_next.capture_pos = 3'd0;
                    state_next.phase       = jss_pkg::PH_DATA;
                end
                jss_pkg::PH_DATA:
                begin
                    state_next.data_shift   = request_byte;
                    state_next.bits_in_data = (state.bits_left < jss_pkg::BYTE_LEN)
                                              ? state.bits_left[3:0] : jss_pkg::BYTE_BITS;
                    state_next.phase        = jss_pkg::PH_SHIFT;
                end
                default:
                begin
                    result.byte_refused = 1'b1;
                end
            endcase
        end
        else if (state.phase == jss_pkg::PH_SHIFT)
        begin
            result.tck_pulse      = 1'b1;
            result.tms            = state.tms_level;
            result.tdi            = state.data_shift[0];
            state_next.data_shift = {1'b0, state.data_shift[7:1]};
            if (state.bits_in_data != 4'd0)
                state_next.bits_in_data = state.bits_in_data - 4'd1;
            if (state.bits_left != 7'd0)
                state_next.bits_left = state.bits_left - 7'd1;

            if (state.capture_on)
            begin
                acc = state.capture_acc | (8'(tdo_sample) << state.capture_pos);
                if (state.capture_pos == jss_pkg::CAP_LAST)
                begin
                    result.response_valid  = 1'b1;
                    result.response_byte   = acc;
                    state_next.capture_acc = 8'd0;
                    state_next.capture_pos = 3'd0;
                end
                else
                begin
                    state_next.capture_acc = acc;
                    state_next.capture_pos = state.capture_pos + 3'd1;
                end
            end

            if (state_next.bits_left == 7'd0)
            begin
                // flush a partial capture byte at sequence end
                if (state.capture_on && state_next.capture_pos != 3'd0)
                begin
                    result.response_valid  = 1'b1;
                    result.response_byte   = state_next.capture_acc;
                    state_next.capture_acc = 8'd0;
                    state_next.capture_pos = 3'd0;
                end
                state_next.bits_in_data = 4'd0;
                if (state.sequences_left != 8'd0)
                    state_next.sequences_left = state.sequences_left - 8'd1;
                if (state_next.sequences_left == 8'd0)
                begin
                    result.done_res  = 1'b1;
                    state_next.phase = jss_pkg::PH_COUNT;
                end
                else
                begin
                    state_next.phase = jss_pkg::PH_INFO;
                end
            end
            else if (state_next.bits_in_data == 4'd0)
            begin
                state_next.phase = jss_pkg::PH_DATA;
            end
        end

        result.need_byte = (state_next.phase != jss_pkg::PH_SHIFT);
    end

endmodule

`default_nettype wire

// ----- rtl/core/jss_checker.sv -----
`default_nettype none

`include "jtag_sequence_shifter_core_defines.svh"

module jss_checker
(
    input wire        clk,
    input wire        rst_n,
    input wire        in_valid,
    input wire        in_ready,
    input wire        operation,
    input wire [7:0]  request_byte,
    input wire        tdo_sample,
    input wire        out_valid,
    input wire        out_ready,
    input wire        tck_pulse,
    input wire        tms,
    input wire        tdi,
    input wire        response_valid,
    input wire [7:0]  response_byte,
    input wire        byte_refused,
    input wire        done_res,
    input wire        need_byte
);

    // a stalled result beat holds
    `JSS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(response_byte) && $stable(tck_pulse) && $stable(done_res))

    // pin levels stay low without a pulse
    `JSS_ASSERT_NOW(a_idle_pins, out_valid && !tck_pulse, !tms && !tdi)

    // no response data without a response beat
    `JSS_ASSERT_NOW(a_resp_zero, out_valid && !response_valid, response_byte == 8'd0)

    // a refused byte leaves the engine shifting
    `JSS_ASSERT_NOW(a_refused, out_valid && byte_refused, !tck_pulse && !need_byte && !done_res && !response_valid)

    // completion always returns to waiting for a byte
    `JSS_ASSERT_NOW(a_done_idle, out_valid && done_res, need_byte)

endmodule

bind jtag_sequence_shifter_core jss_checker u_jss_checker (.*);

`default_nettype wire
